// ===== src/hfe_pkg.sv =====
// Package for the HDLC frame encoder: request codes, CSR map, line constants
// and the command/status structs between controller and datapath.
// No dependencies.
package hfe_pkg;

   typedef enum logic [1:0] {
      REQ_DATA      = 2'd0,
      REQ_FRAME_END = 2'd1,
      REQ_TX_START  = 2'd2,
      REQ_TX_END    = 2'd3
   } req_code_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int FLAG_CNT_W = 6;

   localparam logic REG_PREAMBLE = 1'b0;
   localparam logic REG_TAIL     = 1'b1;

   localparam logic [FLAG_CNT_W-1:0] PREAMBLE_RESET = 6'd30;
   localparam logic [FLAG_CNT_W-1:0] TAIL_RESET     = 6'd10;
   localparam logic [FLAG_CNT_W-1:0] FLAG_LIMIT     = 6'd48;

   localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;

   typedef struct packed {
      logic load;
      logic run_src;
      logic run_flag;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic src_last;
      logic flags_zero;
      logic flag_last;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

   function automatic logic [FLAG_CNT_W-1:0] clamp_flags(input logic [FLAG_CNT_W-1:0] v);
      clamp_flags = (v > FLAG_LIMIT) ? FLAG_LIMIT : v;
   endfunction

endpackage

// ===== src/hdlc_frame_encoder_core.sv =====
// Top level of the HDLC frame encoder: controller, datapath and CSR block.
// Depends on hfe_pkg, hfe_csr, hfe_ctrl and hfe_dp.
//
// The encoder emits one line bit per clock cycle into a bit-serial shifter, unless
// back-pressure stalls it. An item is accepted, its line bits are shifted out
// and the sequencer then checks its flags and flushes it: a data byte with up to
// two stuff bits, a frame end with or without a separator flag, a flag request with
// its flags (clamped to 48) and one more bit for an owed stuff bit. Items are taken
// one at a time; req_ready is high while the sequencer is idle. Completed line bytes
// are held in a pending register so that the final byte of an item carries rsp_last;
// an item that completes no byte returns nothing. Back-pressure on rsp_ready stalls
// the bit shifter once both the pending and output registers are full, and so
// lengthens the item.
module hdlc_frame_encoder_core
   import hfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_more_follows,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_line_byte,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dp_cmd_type            cmd;
   dp_status_type         sts;
   logic [FLAG_CNT_W-1:0] preamble_cnt;
   logic [FLAG_CNT_W-1:0] tail_cnt;

   hfe_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .preamble_cnt (preamble_cnt),
      .tail_cnt     (tail_cnt)
   );

   hfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .sts       (sts),
      .cmd       (cmd)
   );

   hfe_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_more_follows (req_more_follows),
      .preamble_cnt     (preamble_cnt),
      .tail_cnt         (tail_cnt),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== src/hfe_csr.sv =====
// Configuration registers of the HDLC frame encoder behind an APB-style port.
// Depends on hfe_pkg.
module hfe_csr
   import hfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [FLAG_CNT_W-1:0] preamble_cnt,
   output logic [FLAG_CNT_W-1:0] tail_cnt
);

   logic [FLAG_CNT_W-1:0] preamble_ff, preamble_in;
   logic [FLAG_CNT_W-1:0] tail_ff, tail_in;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      preamble_in = preamble_ff;
      tail_in     = tail_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_PREAMBLE: preamble_in = csr_pwdata[FLAG_CNT_W-1:0];
            REG_TAIL:     tail_in     = csr_pwdata[FLAG_CNT_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= PREAMBLE_RESET;
         tail_ff     <= TAIL_RESET;
      end else begin
         preamble_ff <= preamble_in;
         tail_ff     <= tail_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PREAMBLE: csr_prdata = {{(CSR_DATA_W-FLAG_CNT_W){1'b0}}, preamble_ff};
         REG_TAIL:     csr_prdata = {{(CSR_DATA_W-FLAG_CNT_W){1'b0}}, tail_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign preamble_cnt = clamp_flags(preamble_ff);
   assign tail_cnt     = clamp_flags(tail_ff);

endmodule

// ===== src/hfe_ctrl.sv =====
// Controller of the HDLC frame encoder: sequences source bits, flags and the
// final flush of each item. Depends on hfe_pkg.
module hfe_ctrl
   import hfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_type,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SRC,
      ST_FLAG,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   assign cmd.load     = accept;
   assign cmd.run_src  = (state_ff == ST_SRC);
   assign cmd.run_flag = (state_ff == ST_FLAG) & ~sts.flags_zero;
   assign cmd.flush    = (state_ff == ST_FLUSH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_type == REQ_DATA) || (req_type == REQ_FRAME_END)) begin
                  state_in = ST_SRC;
               end else begin
                  state_in = ST_FLAG;
               end
            end
         end
         ST_SRC: begin
            if (sts.src_last) state_in = ST_FLAG;
         end
         ST_FLAG: begin
            if (sts.flags_zero || sts.flag_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!sts.pend_valid || sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/hfe_dp.sv =====
// Datapath of the HDLC frame encoder: bit-serial source and flag shifting,
// zero stuffing, CRC, byte packing, pending and output byte registers.
// Depends on hfe_pkg.
module hfe_dp
   import hfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         sts,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_more_follows,
   input  logic [FLAG_CNT_W-1:0] preamble_cnt,
   input  logic [FLAG_CNT_W-1:0] tail_cnt,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_line_byte,
   output logic                  rsp_last
);

   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            shift_ff, shift_in;
   logic [2:0]            bit_count_ff, bit_count_in;
   logic [15:0]           src_ff, src_in;
   logic [4:0]            src_cnt_ff, src_cnt_in;
   logic                  crc_en_ff, crc_en_in;
   logic [FLAG_CNT_W-1:0] flag_cnt_ff, flag_cnt_in;
   logic [2:0]            fbit_ff, fbit_in;
   logic [7:0]            pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [7:0]            out_ff, out_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_valid_ff, out_valid_in;

   logic       run5, out_free, step, stuff, line_bit, emit, byte_done, real_bit, fb;
   logic [7:0] new_byte;

   assign run5      = &shift_ff[6:2];
   assign out_free  = ~out_valid_ff | rsp_ready;
   assign step      = ~((bit_count_ff == 3'd7) & pend_valid_ff & ~out_free);
   assign stuff     = run5 & (cmd.run_src | (fbit_ff == 3'd0));
   assign line_bit  = stuff ? 1'b0 : (cmd.run_src ? src_ff[0] : FLAG_BYTE[fbit_ff]);
   assign emit      = (cmd.run_src | cmd.run_flag) & step;
   assign real_bit  = emit & ~stuff;
   assign byte_done = emit & (bit_count_ff == 3'd7);
   assign new_byte  = {line_bit, shift_ff[6:0]};
   assign fb        = crc_ff[0] ^ src_ff[0];

   assign sts.src_last   = cmd.run_src & real_bit & (src_cnt_ff == 5'd1);
   assign sts.flags_zero = (flag_cnt_ff == '0);
   assign sts.flag_last  = cmd.run_flag & real_bit & (fbit_ff == 3'd7)
                           & (flag_cnt_ff == {{(FLAG_CNT_W-1){1'b0}}, 1'b1});
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   always_comb begin
      crc_in        = crc_ff;
      shift_in      = shift_ff;
      bit_count_in  = bit_count_ff;
      src_in        = src_ff;
      src_cnt_in    = src_cnt_ff;
      crc_en_in     = crc_en_ff;
      flag_cnt_in   = flag_cnt_ff;
      fbit_in       = fbit_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff;

      if (cmd.load) begin
         fbit_in = 3'd0;
         unique case (req_type)
            REQ_DATA: begin
               src_in      = {8'h00, req_data_byte};
               src_cnt_in  = 5'd8;
               crc_en_in   = 1'b1;
               flag_cnt_in = '0;
            end
            REQ_FRAME_END: begin
               src_in      = ~crc_ff;
               src_cnt_in  = 5'd16;
               crc_en_in   = 1'b0;
               crc_in      = CRC_PRESET;
               flag_cnt_in = {{(FLAG_CNT_W-1){1'b0}}, req_more_follows};
            end
            REQ_TX_START: begin
               crc_in      = CRC_PRESET;
               flag_cnt_in = preamble_cnt;
            end
            REQ_TX_END: begin
               flag_cnt_in = tail_cnt;
            end
            default: ;
         endcase
      end

      if (emit) begin
         shift_in     = {1'b0, line_bit, shift_ff[6:1]};
         bit_count_in = bit_count_ff + 3'd1;
      end

      if (real_bit && cmd.run_src) begin
         src_in     = {1'b0, src_ff[15:1]};
         src_cnt_in = src_cnt_ff - 5'd1;
         if (crc_en_ff) begin
            crc_in = {1'b0, crc_ff[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
         end
      end

      if (real_bit && cmd.run_flag) begin
         fbit_in = fbit_ff + 3'd1;
         if (fbit_ff == 3'd7) flag_cnt_in = flag_cnt_ff - {{(FLAG_CNT_W-1){1'b0}}, 1'b1};
      end

      priority if (byte_done && pend_valid_ff) begin
         out_in       = pend_ff;
         out_last_in  = 1'b0;
         out_valid_in = 1'b1;
      end else if (cmd.flush && pend_valid_ff && out_free) begin
         out_in       = pend_ff;
         out_last_in  = 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      priority if (byte_done) begin
         pend_in       = new_byte;
         pend_valid_in = 1'b1;
      end else if (cmd.flush && out_free) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CRC_PRESET;
         shift_ff      <= '0;
         bit_count_ff  <= '0;
         src_cnt_ff    <= '0;
         crc_en_ff     <= 1'b0;
         flag_cnt_ff   <= '0;
         fbit_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         shift_ff      <= shift_in;
         bit_count_ff  <= bit_count_in;
         src_cnt_ff    <= src_cnt_in;
         crc_en_ff     <= crc_en_in;
         flag_cnt_ff   <= flag_cnt_in;
         fbit_ff       <= fbit_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_line_byte = out_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ===== sim/hfe_line_monitor.sv =====
// Line byte monitor for the HDLC frame encoder: follows the request, result and CSR
// traffic, predicts the packed line bytes of each request, compares them with the
// results and checks CSR read data. Depends on hfe_pkg.
`timescale 1ns / 100ps

module hfe_line_monitor
   import hfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_more_follows,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [7:0]            rsp_line_byte,
   input  logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    items_seen,
   output int                    bytes_checked
);

   typedef struct packed {
      logic [7:0] line_byte;
      logic       last;
   } line_word_type;

   line_word_type          line_bytes_due[$];
   line_word_type          item_bytes[$];
   logic [15:0]            fcs_acc;
   logic [7:0]             line_window;
   logic [2:0]             bits_held;
   logic [FLAG_CNT_W-1:0]  preamble_cnt;
   logic [FLAG_CNT_W-1:0]  tail_cnt;
   int                     fails;
   int                     items;
   int                     bytes;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      items_seen    = 0;
      bytes_checked = 0;
      fails         = 0;
      items         = 0;
      bytes         = 0;
   end

   function automatic void note_fail();
      fails++;
   endfunction

   function automatic void put_line_bit(input logic b);
      line_word_type w;
      line_window = line_window | {b, 7'b0};
      bits_held   = bits_held + 3'd1;
      if (bits_held == 3'd0 && item_bytes.size() < 49) begin
         w.line_byte = line_window;
         w.last      = 1'b0;
         item_bytes.push_back(w);
      end
      line_window = line_window >> 1;
   endfunction

   function automatic logic five_ones();
      return (line_window & 8'h7C) == 8'h7C;
   endfunction

   function automatic void send_octet(input logic [7:0] v);
      int k;
      k = 0;
      while (k < 8) begin
         if (five_ones()) begin
            put_line_bit(1'b0);
         end else begin
            put_line_bit(v[k]);
            k++;
         end
      end
   endfunction

   function automatic void send_flag();
      int k;
      if (five_ones())
         put_line_bit(1'b0);
      for (k = 0; k < 8; k++)
         put_line_bit(FLAG_BYTE[k]);
   endfunction

   function automatic void send_flags(input logic [FLAG_CNT_W-1:0] count);
      int n;
      int k;
      n = (count > FLAG_LIMIT) ? int'(FLAG_LIMIT) : int'(count);
      for (k = 0; k < n; k++)
         send_flag();
   endfunction

   function automatic void fold_fcs(input logic [7:0] v);
      logic [15:0] c;
      int          k;
      c = fcs_acc ^ {8'h00, v};
      for (k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      fcs_acc = c;
   endfunction

   function automatic void predict_item(input req_code_type kind, input logic [7:0] data,
                                        input logic more);
      logic [15:0] c;
      item_bytes.delete();
      case (kind)
         REQ_DATA: begin
            fold_fcs(data);
            send_octet(data);
         end
         REQ_FRAME_END: begin
            c = fcs_acc;
            send_octet(~c[7:0]);
            send_octet(~c[15:8]);
            fcs_acc = CRC_PRESET;
            if (more)
               send_flag();
         end
         REQ_TX_START: begin
            fcs_acc = CRC_PRESET;
            send_flags(preamble_cnt);
         end
         default: begin
            send_flags(tail_cnt);
         end
      endcase
      if (item_bytes.size() > 0)
         item_bytes[item_bytes.size()-1].last = 1'b1;
      foreach (item_bytes[i])
         line_bytes_due.push_back(item_bytes[i]);
   endfunction

   always @(posedge clock) begin
      line_word_type         want;
      logic [FLAG_CNT_W-1:0] reg_val;
      if (reset) begin
         fcs_acc      = CRC_PRESET;
         line_window  = 8'h00;
         bits_held    = 3'd0;
         preamble_cnt = PREAMBLE_RESET;
         tail_cnt     = TAIL_RESET;
         line_bytes_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_PREAMBLE)
                  preamble_cnt = csr_pwdata[FLAG_CNT_W-1:0];
               else
                  tail_cnt = csr_pwdata[FLAG_CNT_W-1:0];
            end else begin
               reg_val = (csr_paddr[2] == REG_PREAMBLE) ? preamble_cnt : tail_cnt;
               if (csr_prdata[FLAG_CNT_W-1:0] !== reg_val) begin
                  note_fail();
                  if (fails <= 100)
                     $display("%0t: csr read at %0h, expected %0d got %0d", $time,
                              csr_paddr, reg_val, csr_prdata[FLAG_CNT_W-1:0]);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (line_bytes_due.size() == 0) begin
               note_fail();
               if (fails <= 100)
                  $display("%0t: line byte %02h (last %0b) with nothing expected, expected none",
                           $time, rsp_line_byte, rsp_last);
            end else begin
               want = line_bytes_due.pop_front();
               bytes++;
               if (rsp_line_byte !== want.line_byte) begin
                  note_fail();
                  if (fails <= 100)
                     $display("%0t: line byte, expected %02h got %02h", $time,
                              want.line_byte, rsp_line_byte);
               end
               if (rsp_last !== want.last) begin
                  note_fail();
                  if (fails <= 100)
                     $display("%0t: last flag on byte %02h, expected %0b got %0b", $time,
                              want.line_byte, want.last, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_item(req_code_type'(req_type), req_data_byte, req_more_follows);
            items++;
         end
      end
      fail_count    <= fails;
      pending_count <= line_bytes_due.size();
      items_seen    <= items;
      bytes_checked <= bytes;
   end

endmodule

// ===== sim/tb_hdlc_frame_encoder_core.sv =====
// Testbench top for hdlc_frame_encoder_core: drives requests, flag count writes and
// result back-pressure, and reports the verdict. Depends on hfe_pkg, the encoder RTL
// and hfe_line_monitor.
`timescale 1ns / 100ps

module tb_hdlc_frame_encoder_core;
   import hfe_pkg::*;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_type         = REQ_DATA;
   logic [7:0]            req_data_byte    = 8'h00;
   logic                  req_more_follows = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [7:0]            rsp_line_byte;
   logic                  rsp_last;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending_count;
   int items_seen;
   int bytes_checked;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int settings_used = 0;

   always #2 clock = ~clock;

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   hdlc_frame_encoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_more_follows (req_more_follows),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   hfe_line_monitor u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_more_follows (req_more_follows),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .items_seen       (items_seen),
      .bytes_checked    (bytes_checked)
   );

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic send_req(input req_code_type kind, input logic [7:0] data,
                           input logic more);
      int gap;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_data_byte    <= data;
      req_more_follows <= more;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // drop valid, drain the expected bytes, then let the sequencer finish
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic reg_sel,
                             input logic [FLAG_CNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[FLAG_CNT_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_flags(input logic [FLAG_CNT_W-1:0] pre,
                            input logic [FLAG_CNT_W-1:0] tail);
      settle(500);
      csr_access(1'b1, REG_PREAMBLE, pre);
      csr_access(1'b1, REG_TAIL, tail);
      csr_access(1'b0, REG_PREAMBLE, '0);
      csr_access(1'b0, REG_TAIL, '0);
      settings_used++;
   endtask

   function automatic logic [7:0] pick_octet();
      case ($urandom_range(3))
         0:       return 8'hFF;
         1:       return 8'($urandom_range(255) | $urandom_range(255));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_transmission();
      int frames;
      int octets;
      int f;
      int b;
      frames = $urandom_range(1, 3);
      send_req(REQ_TX_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
      for (f = 0; f < frames; f++) begin
         octets = $urandom_range(0, 6);
         for (b = 0; b < octets; b++)
            send_req(REQ_DATA, pick_octet(), 1'($urandom_range(1)));
         send_req(REQ_FRAME_END, 8'($urandom_range(255)), f != frames - 1);
      end
      send_req(REQ_TX_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall);
      int target;
      target = items_sent + count;
      send_idle_pct = idle_pct;
      stall_pct    <= stall;
      while (items_sent < target) begin
         if ($urandom_range(99) < 80)
            send_transmission();
         else
            send_req(req_code_type'($urandom_range(3)), pick_octet(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset flag counts first
      send_req(REQ_TX_START,  8'hA5, 1'b1);
      send_req(REQ_DATA,      8'h00, 1'b1);
      send_req(REQ_DATA,      8'hFF, 1'b0);
      send_req(REQ_DATA,      8'hFF, 1'b1);
      send_req(REQ_DATA,      8'h7E, 1'b0);
      send_req(REQ_DATA,      8'hF8, 1'b0);
      send_req(REQ_FRAME_END, 8'h5A, 1'b1);
      send_req(REQ_DATA,      8'h01, 1'b0);
      send_req(REQ_DATA,      8'h80, 1'b1);
      send_req(REQ_DATA,      8'hAA, 1'b0);
      send_req(REQ_DATA,      8'h55, 1'b0);
      send_req(REQ_FRAME_END, 8'hFF, 1'b0);
      send_req(REQ_TX_END,    8'hC3, 1'b1);
      send_req(REQ_FRAME_END, 8'h00, 1'b1);
      send_req(REQ_DATA,      8'h1F, 1'b1);

      set_flags(6'd0, 6'd0);
      send_req(REQ_TX_START,  8'hFF, 1'b0);
      send_req(REQ_TX_END,    8'h00, 1'b0);
      send_req(REQ_DATA,      8'hF8, 1'b0);
      send_req(REQ_TX_END,    8'h3C, 1'b1);

      set_flags(FLAG_LIMIT, 6'd63);
      send_req(REQ_TX_START,  8'h81, 1'b0);
      send_req(REQ_DATA,      8'hF8, 1'b0);
      send_req(REQ_TX_END,    8'h7E, 1'b0);

      set_flags(6'd2, 6'd3);
      run_phase(32, 0, 0);
      set_flags(6'd1, 6'd49);
      run_phase(32, 70, 0);
      set_flags(6'($urandom_range(63)), 6'($urandom_range(63)));
      run_phase(32, 0, 70);
      set_flags(6'd4, 6'd0);
      run_phase(32, 18, 18);

      settle(500);
      $display("summary: %0d requests under %0d flag count settings, %0d line bytes compared",
               items_seen, settings_used + 1, bytes_checked);
      $display("summary: idling phases none, sender 70%%, receiver 70%%, both 18%%");
      if (fail_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
